// File: hdl/five_voice_waveform_mixer_assert.svh
// assertion macros for the five-voice waveform mixer
`ifndef FIVE_VOICE_WAVEFORM_MIXER_ASSERT_SVH
`define FIVE_VOICE_WAVEFORM_MIXER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define FVWM_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mixer check failed: same-cycle rule");

// next-cycle implication, checked outside reset
`define FVWM_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mixer check failed: next-cycle rule");

`else

`define FVWM_ASSERT_NOW(label, clk, rst, cond, expr)
`define FVWM_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// File: hdl/fvwm_pkg.sv
// shared types, codes and constant functions for the waveform mixer
package fvwm_pkg;

   localparam int VOICES = 5;

   // voice numbers
   localparam logic [2:0] VOICE_SINE     = 3'd0;
   localparam logic [2:0] VOICE_PULSE    = 3'd1;
   localparam logic [2:0] VOICE_TRIANGLE = 3'd2;
   localparam logic [2:0] VOICE_SAW      = 3'd3;
   localparam logic [2:0] VOICE_NOISE    = 3'd4;

   // request op codes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // csr indexes
   localparam logic [1:0] CSR_MAIN_GAIN     = 2'd0;
   localparam logic [1:0] CSR_PULSE_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_ENABLE = 2'd2;

   // reset values
   localparam logic [8:0]  MAIN_GAIN_RESET     = 9'd179;
   localparam logic [16:0] PULSE_WIDTH_RESET   = 17'd32768;
   localparam logic [31:0] VOICE_STEP_RESET    = 32'd42852281;
   localparam logic [8:0]  VOICE_GAIN_RESET    = 9'd128;
   localparam logic [15:0] NOISE_SEED          = 16'hACE1;

   // reciprocal scale for the averaging multiply
   localparam int RECIP_SHIFT = 24;

   // pi/2 in Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCALE  = 7'b0000010,
      S_SUM    = 7'b0000100,
      S_DIV    = 7'b0001000,
      S_SIGN   = 7'b0010000,
      S_MASTER = 7'b0100000,
      S_OUT    = 7'b1000000
   } seq_state_type;

   // quarter-wave sine entry by a fixed-point taylor series, elaboration only
   function automatic logic [14:0] quarter_sine(input int unsigned k, input int unsigned qbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      logic signed [63:0] r;
      x    = (64'(k) * HALF_PI_Q30) >> qbits;
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if ((n % 2) == 1) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      r = (acc * 64'sd32767 + 64'sd536870912) >>> 30;
      if (r > 64'sd32767) begin
         r = 64'sd32767;
      end
      return r[14:0];
   endfunction

   // ceil(2^24 / n) for the active voice count, exact for sums below 2^19
   function automatic logic [24:0] recip(input logic [2:0] n);
      logic [24:0] r;
      case (n)
         3'd1:    r = 25'd16777216;
         3'd2:    r = 25'd8388608;
         3'd3:    r = 25'd5592406;
         3'd4:    r = 25'd4194304;
         3'd5:    r = 25'd3355444;
         default: r = 25'd0;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/five_voice_waveform_mixer.sv
// five-voice waveform mixer: sine, pulse, triangle, sawtooth and noise on one shared multiplier
// req channel carries either a voice settings write (no result) or a sample tick (one rsp beat).
// a write beat is absorbed at the edge that accepts it; req_ready stays high for the next beat.
// a tick walks the five voices under a small sequencer: a scale by gain and then an accumulate
// step for each enabled voice, a single skipping step for each disabled voice, then the
// reciprocal divide by the active count, sign fix, master scaling and saturation.
// req_ready is low while a tick runs, so no new request is taken until the sequencer is
// back in idle; the steps run in series because they share the single multiplier.
// rsp_sample sits in an output register; the next tick can run while it waits, and only the
// final step holds if the previous beat is still not taken by rsp_ready.
// csr port: csr_we writes csr_data into the register at csr_index, no read-back.
// only write csrs while the block is idle.
// synchronous reset restores the csrs, clears phases and enables, sets steps to 440 Hz,
// gains to half and seeds the noise register; no output beat is pending after reset.
module five_voice_waveform_mixer #(
   parameter int SINE_INDEX_BITS = 10
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic [2:0]         req_voice,
   input  logic               req_voice_on,
   input  logic [31:0]        req_step,
   input  logic [8:0]         req_gain,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   // csr write port
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);

   import fvwm_pkg::*;

   localparam int QTR_BITS = SINE_INDEX_BITS - 2;
   localparam int QTR      = 1 << QTR_BITS;
   localparam logic [QTR_BITS:0] QTR_ADDR = {1'b1, {QTR_BITS{1'b0}}};

   typedef logic [14:0] rom_type [0:QTR];

   function automatic rom_type build_rom();
      rom_type t;
      for (int k = 0; k <= QTR; k++) begin
         t[k] = quarter_sine(k, QTR_BITS);
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // control state
   seq_state_type state_ff, state_in;
   logic [2:0]    voice_ff, voice_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [8:0]    master_ff, master_in;
   logic [16:0]   duty_ff, duty_in;
   logic          oe_ff, oe_in;
   logic [31:0]   phase_ff [VOICES];
   logic [31:0]   phase_in [VOICES];
   logic [31:0]   step_ff [VOICES];
   logic [31:0]   step_in [VOICES];
   logic [8:0]    gain_ff [VOICES];
   logic [8:0]    gain_in [VOICES];
   logic [VOICES-1:0] enable_ff, enable_in;
   logic [15:0]   noise_ff, noise_in;

   // datapath registers
   logic signed [46:0] prod_ff, prod_in;
   logic signed [19:0] total_ff, total_in;
   logic signed [19:0] avg_ff, avg_in;
   logic               neg_ff, neg_in;
   logic [2:0]         count_ff, count_in;
   logic signed [15:0] sample_ff, sample_in;
   logic [14:0]        sine_mag_ff;

   // shared multiplier
   logic signed [20:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [46:0] mul_p;

   logic [QTR_BITS-1:0] sine_k;
   logic [QTR_BITS:0]   rom_addr;
   logic [31:0]         phase_rd;
   logic [15:0]         u;
   logic signed [17:0]  tri_wave;
   logic                noise_fb;
   logic [15:0]         noise_next;
   logic signed [15:0]  voice_val;
   logic [19:0]         total_mag;
   logic [19:0]         quot;
   logic signed [20:0]  level;
   logic signed [15:0]  level_sat;
   logic                req_fire;
   logic                out_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;
   assign req_fire   = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   // sine rom address from voice 0 phase, mirrored in odd quadrants
   assign sine_k   = phase_ff[0][29 -: QTR_BITS];
   assign rom_addr = phase_ff[0][30] ? (QTR_ADDR - {1'b0, sine_k}) : {1'b0, sine_k};

   always_ff @(posedge clock) begin
      sine_mag_ff <= SINE_ROM[rom_addr];
   end

   // noise lfsr step
   assign noise_fb   = noise_ff[0] ^ noise_ff[1] ^ noise_ff[3] ^ noise_ff[12];
   assign noise_next = {noise_fb, noise_ff[15:1]};

   // current voice waveform value
   assign phase_rd = phase_ff[voice_ff];
   assign u        = phase_rd[31:16];

   always_comb begin
      if (u < 16'd16384) begin
         tri_wave = signed'({1'b0, u, 1'b0});
      end else if (u < 16'd49152) begin
         tri_wave = 18'sd65536 - signed'({1'b0, u, 1'b0});
         if (tri_wave == 18'sd32768) begin
            tri_wave = 18'sd32767;
         end
      end else begin
         tri_wave = signed'({1'b0, u, 1'b0}) - 18'sd131072;
      end
   end

   always_comb begin
      unique case (voice_ff)
         VOICE_SINE: begin
            voice_val = phase_ff[0][31] ? -signed'({1'b0, sine_mag_ff})
                                        : signed'({1'b0, sine_mag_ff});
         end
         VOICE_PULSE: begin
            voice_val = ({1'b0, u} < duty_ff) ? 16'sd32767 : -16'sd32768;
         end
         VOICE_TRIANGLE: voice_val = tri_wave[15:0];
         VOICE_SAW:      voice_val = signed'({~u[15], u[14:0]});
         VOICE_NOISE:    voice_val = signed'({~noise_next[15], noise_next[14:0]});
         default:        voice_val = 16'sd0;
      endcase
   end

   // averaging and saturation helpers
   assign total_mag = total_ff[19] ? 20'(-total_ff) : 20'(total_ff);
   assign quot      = prod_ff[RECIP_SHIFT+19:RECIP_SHIFT];
   assign level     = prod_ff[28:8];

   always_comb begin
      if (level > 21'sd32767) begin
         level_sat = 16'sd32767;
      end else if (level < -21'sd32768) begin
         level_sat = -16'sd32768;
      end else begin
         level_sat = level[15:0];
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = 21'sd0;
      mul_b = 26'sd0;
      case (state_ff)
         S_SCALE: begin
            mul_a = 21'(voice_val);
            mul_b = signed'({17'd0, gain_ff[voice_ff]});
         end
         S_DIV: begin
            mul_a = signed'({1'b0, total_mag});
            mul_b = signed'({1'b0, recip(count_ff)});
         end
         S_MASTER: begin
            mul_a = 21'(avg_ff);
            mul_b = signed'({17'd0, master_ff});
         end
         default: begin
            mul_a = 21'sd0;
            mul_b = 26'sd0;
         end
      endcase
   end

   assign mul_p = 47'(mul_a) * 47'(mul_b);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      voice_in     = voice_ff;
      rsp_valid_in = rsp_valid_ff;
      master_in    = master_ff;
      duty_in      = duty_ff;
      oe_in        = oe_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      gain_in      = gain_ff;
      enable_in    = enable_ff;
      noise_in     = noise_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      avg_in       = avg_ff;
      neg_in       = neg_ff;
      count_in     = count_ff;
      sample_in    = sample_ff;

      // response beat taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // csr writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAIN_GAIN:     master_in = csr_data[8:0];
            CSR_PULSE_WIDTH:   duty_in   = csr_data;
            CSR_OUTPUT_ENABLE: oe_in     = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_WRITE) begin
                  if (req_voice < 3'(VOICES)) begin
                     enable_in[req_voice] = req_voice_on;
                     step_in[req_voice]   = req_step;
                     gain_in[req_voice]   = req_gain;
                  end
               end else begin
                  voice_in = VOICE_SINE;
                  total_in = 20'sd0;
                  count_in = 3'd0;
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            if (enable_ff[voice_ff]) begin
               prod_in            = mul_p;
               phase_in[voice_ff] = phase_ff[voice_ff] + step_ff[voice_ff];
               count_in           = count_ff + 3'd1;
               if (voice_ff == VOICE_NOISE) begin
                  noise_in = noise_next;
               end
               state_in = S_SUM;
            end else if (voice_ff == VOICE_NOISE) begin
               state_in = S_DIV;
            end else begin
               voice_in = voice_ff + 3'd1;
            end
         end
         S_SUM: begin
            total_in = total_ff + signed'(prod_ff[27:8]);
            if (voice_ff == VOICE_NOISE) begin
               state_in = S_DIV;
            end else begin
               voice_in = voice_ff + 3'd1;
               state_in = S_SCALE;
            end
         end
         S_DIV: begin
            prod_in  = mul_p;
            neg_in   = total_ff[19];
            state_in = S_SIGN;
         end
         S_SIGN: begin
            avg_in   = neg_ff ? -signed'(quot) : signed'(quot);
            state_in = S_MASTER;
         end
         S_MASTER: begin
            prod_in  = mul_p;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               sample_in    = oe_ff ? level_sat : 16'sd0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         voice_ff     <= VOICE_SINE;
         rsp_valid_ff <= 1'b0;
         master_ff    <= MAIN_GAIN_RESET;
         duty_ff      <= PULSE_WIDTH_RESET;
         oe_ff        <= 1'b1;
         for (int i = 0; i < VOICES; i++) begin
            phase_ff[i] <= 32'd0;
            step_ff[i]  <= VOICE_STEP_RESET;
            gain_ff[i]  <= VOICE_GAIN_RESET;
         end
         enable_ff    <= '0;
         noise_ff     <= NOISE_SEED;
      end else begin
         state_ff     <= state_in;
         voice_ff     <= voice_in;
         rsp_valid_ff <= rsp_valid_in;
         master_ff    <= master_in;
         duty_ff      <= duty_in;
         oe_ff        <= oe_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         gain_ff      <= gain_in;
         enable_ff    <= enable_in;
         noise_ff     <= noise_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      total_ff  <= total_in;
      avg_ff    <= avg_in;
      neg_ff    <= neg_in;
      count_ff  <= count_in;
      sample_ff <= sample_in;
   end

   `include "five_voice_waveform_mixer_assert.svh"

   // a tick beat starts the voice walk at voice 0
   `FVWM_ASSERT_NEXT(a_tick_starts, clock, reset, req_fire && (req_op == OP_TICK), (state_ff == S_SCALE) && (voice_ff == VOICE_SINE))
   // a settings write never produces a beat and leaves the block idle
   `FVWM_ASSERT_NEXT(a_write_idle, clock, reset, req_fire && (req_op == OP_WRITE), (state_ff == S_IDLE) && !$rose(rsp_valid))
   // the walk never passes the last voice and the count never exceeds the voice total
   `FVWM_ASSERT_NOW(a_voice_range, clock, reset, state_ff != S_IDLE, (voice_ff <= VOICE_NOISE) && (count_ff <= 3'd5))
   // a muted block emits silence
   `FVWM_ASSERT_NEXT(a_mute_zero, clock, reset, (state_ff == S_OUT) && out_free && !oe_ff, rsp_valid && (rsp_sample == 16'sd0))

endmodule
